// ----- sv/tdr_pkg.sv -----
// Package for the typed device registry: item structs, status codes,
// chain token and write command types. No dependencies.
package tdr_pkg;

  localparam int NUM_TYPES = 5;
  localparam int TYPE_W    = 3;
  localparam int FIELD_W   = 8;

  typedef enum logic [1:0] {
    ST_KNOWN   = 2'd0,
    ST_ADDED   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } tdr_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } tdr_state_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  node_type;
    logic [FIELD_W-1:0] post_id;
    logic [FIELD_W-1:0] board_id;
  } tdr_in_t;

  typedef struct packed {
    tdr_status_t status;
    logic [2:0]  slot;
    logic [3:0]  type_count;
  } tdr_out_t;

  typedef struct packed {
    logic live;
    logic hit;
  } tdr_tok_t;

  typedef struct packed {
    logic              en;
    logic [TYPE_W-1:0] node_type;
  } tdr_wr_t;

endpackage

// ----- sv/tdr_cell.sv -----
// One slot of the registry chain: holds this slot's entry for every node type,
// compares the passing search token and hands it to the next cell.
// Depends on tdr_pkg.
module tdr_cell import tdr_pkg::*; #(
  parameter int KEY_W    = 16,
  parameter int SLOT_W   = 3,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tdr_tok_t          tok_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [TYPE_W-1:0] qtype,
  input  logic [KEY_W-1:0]  qkey,
  input  tdr_wr_t           wr,
  input  logic [SLOT_W-1:0] wr_slot,
  output tdr_tok_t          tok_o,
  output logic [SLOT_W-1:0] slot_o
);

  logic [KEY_W-1:0]     ids_r [NUM_TYPES];
  logic [NUM_TYPES-1:0] valid_r;
  tdr_tok_t             tok_r;
  tdr_tok_t             tok_nxt;
  logic [SLOT_W-1:0]    slot_r;
  logic [SLOT_W-1:0]    slot_nxt;
  logic                 match;
  logic                 wr_hit;

  always_comb begin
    match = tok_i.live && (qtype < TYPE_W'(NUM_TYPES)) && valid_r[qtype]
            && (ids_r[qtype] == qkey);
    wr_hit = wr.en && (wr_slot == SLOT_W'(CELL_IDX))
             && (wr.node_type < TYPE_W'(NUM_TYPES));
    tok_nxt.live = tok_i.live;
    tok_nxt.hit  = tok_i.live && (tok_i.hit || match);
    slot_nxt     = match ? SLOT_W'(CELL_IDX) : slot_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_hit) begin
        valid_r[wr.node_type] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (wr_hit) begin
      ids_r[wr.node_type] <= qkey;
    end
  end

  assign tok_o  = tok_r;
  assign slot_o = slot_r;

endmodule

// ----- sv/typed_device_registry.sv -----
// Top level of the typed device registry: control sequencer, fill counts
// and the chain of slot cells. Depends on tdr_pkg and tdr_cell.
//
// Usage: an input item carries a node type, a post id and a board id. The
// block looks the pair up in that type's table and returns one result item
// with a status, the slot found or added, and the type's fill count.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. One item is processed at a time: in_stall is high from the
// accepting edge until the result has been loaded into the output register.
// A search token walks the chain of MAX_DEVICES cells, one cell per cycle.
// When it leaves the last cell the lookup result is registered, and the
// sequencer loads the output register once it is free; an item of an
// unknown type skips the chain and goes straight to that load.
// A stalled result holds in the output register; the next item may be
// accepted meanwhile, and its result waits until the register frees.
// Reset clears all tables, fill counts and both channels' control state.
module typed_device_registry import tdr_pkg::*; #(
  parameter int MAX_DEVICES = 8,
  parameter int ID_BITS     = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tdr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tdr_out_t out_data
);

  localparam int ID_USE = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
  localparam int KEY_W  = 2 * ID_USE;
  localparam int SLOT_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W  = $clog2(MAX_DEVICES + 1);

  tdr_state_t        state_r, state_nxt;
  logic [TYPE_W-1:0] q_type_r, q_type_nxt;
  logic [KEY_W-1:0]  q_key_r, q_key_nxt;
  logic              q_unknown_r, q_unknown_nxt;
  logic              start_r, start_nxt;
  logic              hit_r, hit_nxt;
  logic [SLOT_W-1:0] hslot_r, hslot_nxt;
  logic [CNT_W-1:0]  counts_r [NUM_TYPES];
  logic [CNT_W-1:0]  counts_nxt [NUM_TYPES];
  logic              out_valid_r, out_valid_nxt;
  tdr_out_t          out_data_r, out_data_nxt;
  logic [CNT_W-1:0]  cur_cnt;
  logic              in_unknown;
  tdr_wr_t           wr;
  logic [SLOT_W-1:0] wr_slot;

  tdr_tok_t          tok_c  [MAX_DEVICES+1];
  logic [SLOT_W-1:0] slot_c [MAX_DEVICES+1];
  logic [MAX_DEVICES-1:0] live_v;

  assign tok_c[0].live = start_r;
  assign tok_c[0].hit  = 1'b0;
  assign slot_c[0]     = '0;

  for (genvar g = 0; g < MAX_DEVICES; g++) begin : g_cell
    tdr_cell #(
      .KEY_W   (KEY_W),
      .SLOT_W  (SLOT_W),
      .CELL_IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok_c[g]),
      .slot_i (slot_c[g]),
      .qtype  (q_type_r),
      .qkey   (q_key_r),
      .wr     (wr),
      .wr_slot(wr_slot),
      .tok_o  (tok_c[g+1]),
      .slot_o (slot_c[g+1])
    );
    assign live_v[g] = tok_c[g+1].live;
  end

  assign in_unknown = (in_data.node_type >= TYPE_W'(NUM_TYPES));
  assign cur_cnt    = q_unknown_r ? '0 : counts_r[q_type_r];

  always_comb begin
    state_nxt     = state_r;
    q_type_nxt    = q_type_r;
    q_key_nxt     = q_key_r;
    q_unknown_nxt = q_unknown_r;
    start_nxt     = 1'b0;
    hit_nxt       = hit_r;
    hslot_nxt     = hslot_r;
    counts_nxt    = counts_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr.en         = 1'b0;
    wr.node_type  = q_type_r;
    wr_slot       = SLOT_W'(cur_cnt);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          q_type_nxt    = in_data.node_type;
          q_key_nxt     = {in_data.post_id[ID_USE-1:0], in_data.board_id[ID_USE-1:0]};
          q_unknown_nxt = in_unknown;
          start_nxt     = !in_unknown;
          state_nxt     = in_unknown ? S_FINISH : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tok_c[MAX_DEVICES].live) begin
          hit_nxt   = tok_c[MAX_DEVICES].hit;
          hslot_nxt = slot_c[MAX_DEVICES];
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (q_unknown_r) begin
            out_data_nxt.status     = ST_UNKNOWN;
            out_data_nxt.slot       = '0;
            out_data_nxt.type_count = '0;
          end else if (hit_r) begin
            out_data_nxt.status     = ST_KNOWN;
            out_data_nxt.slot       = 3'(hslot_r);
            out_data_nxt.type_count = 4'(cur_cnt);
          end else if (cur_cnt < CNT_W'(MAX_DEVICES)) begin
            wr.en                   = 1'b1;
            counts_nxt[q_type_r]    = cur_cnt + CNT_W'(1);
            out_data_nxt.status     = ST_ADDED;
            out_data_nxt.slot       = 3'(cur_cnt);
            out_data_nxt.type_count = 4'(cur_cnt + CNT_W'(1));
          end else begin
            out_data_nxt.status     = ST_FULL;
            out_data_nxt.slot       = '0;
            out_data_nxt.type_count = 4'(cur_cnt);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        counts_r[t] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      counts_r    <= counts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_type_r    <= q_type_nxt;
    q_key_r     <= q_key_nxt;
    q_unknown_r <= q_unknown_nxt;
    hit_r       <= hit_nxt;
    hslot_r     <= hslot_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic counts_ok;
  always_comb begin
    counts_ok = 1'b1;
    for (int t = 0; t < NUM_TYPES; t++) begin
      if (counts_r[t] > CNT_W'(MAX_DEVICES)) begin
        counts_ok = 1'b0;
      end
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(live_v) <= 1)
    else $error("More than one search item is in the chain.");

  a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    counts_ok)
    else $error("A fill count exceeds the table depth.");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (!q_unknown_r && cur_cnt < CNT_W'(MAX_DEVICES)))
    else $error("Slot write issued for a full table or an unknown type.");

  a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && tok_c[MAX_DEVICES].live) |=> (state_r == S_FINISH))
    else $error("Search item left the chain without finishing the lookup.");

endmodule
